// ===== rtl/rltm_pkg.sv =====
// Shared types and constants for the Reinhard luminance tone map core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rltm_pkg;

  // Channel and register widths
  localparam int CH_W       = 24;
  localparam int GAIN_W     = 24;
  localparam int WSQ_W      = 17;
  localparam int LUM_W      = 24;
  localparam int PROD_W     = CH_W + GAIN_W;   // exposure product
  localparam int WT_W       = 16;              // luminance weights, Q0.16
  localparam int WPROD_W    = CH_W + WT_W;     // weighted channel
  localparam int NUM_W      = 42;              // 2^32 + lum*wsq
  localparam int DEN_W      = 25;              // 65536 + lum
  localparam int SCL_W      = 25;              // scale quotient, Q.24
  localparam int DIV_STEPS  = SCL_W;           // one quotient bit per stage
  localparam int MUL_W      = CH_W + SCL_W;    // channel times scale
  localparam int DATA_W     = 3 * CH_W;        // packed pixel word

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WHITE_SQ  = CFG_IDX_W'(1);

  // Register reset values: gain 1.0, white point 2
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);
  localparam logic [WSQ_W-1:0]  WSQ_RESET  = WSQ_W'(16384);

  // Arithmetic constants
  localparam logic [CH_W-1:0]  CH_MAX     = '1;
  localparam logic [LUM_W-1:0] LUM_THRESH = LUM_W'(65);  // 0.001 in Q8.16
  localparam logic [DEN_W-1:0] ONE_Q16    = DEN_W'(65536);
  localparam logic [NUM_W-1:0] ONE_Q32    = NUM_W'(64'h1_0000_0000);

  // BT.709 weights, red / green / blue, summing to 1.0 in Q0.16
  localparam logic [WT_W-1:0] LUM_WT [3] = '{WT_W'(13933), WT_W'(46871), WT_W'(4732)};

  // Pixel: element 0 red, 1 green, 2 blue (red in the low bits)
  typedef logic [2:0][CH_W-1:0] pix_t;

  // Word from the front stages into the divider
  typedef struct packed {
    pix_t             pix;
    logic             bright;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_in_t;

  // Word from the divider into the back stages
  typedef struct packed {
    pix_t             pix;
    logic             bright;
    logic [SCL_W-1:0] scale;
  } div_out_t;

endpackage

// ===== rtl/rltm_front.sv =====
// Front stages: exposure gain with saturation, BT.709 luminance,
// and the numerator / denominator of the scale. Uses rltm_pkg.
`timescale 1ns / 1ps

module rltm_front import rltm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [GAIN_W-1:0] gain,
  input  logic [WSQ_W-1:0]  wsq,
  input  logic              up_valid,
  output logic              up_ready,
  input  pix_t              up_pix,
  output logic              dn_valid,
  input  logic              dn_ready,
  output div_in_t           dn_data
);

  logic [3:0] v_r;
  logic [3:0] rdy;

  logic [2:0][PROD_W-1:0]  s1_prod_r, s1_prod_nxt;
  pix_t                    s2_pix_r, s2_pix_nxt;
  logic [2:0][WPROD_W-1:0] s2_wp_r, s2_wp_nxt;
  pix_t                    s3_pix_r;
  logic [LUM_W-1:0]        s3_lum_r, s3_lum_nxt;
  logic [WPROD_W+1:0]      s3_sum;
  pix_t                    s4_pix_r;
  logic                    s4_bright_r, s4_bright_nxt;
  logic [NUM_W-1:0]        s4_num_r, s4_num_nxt;
  logic [DEN_W-1:0]        s4_den_r, s4_den_nxt;

  // Stage load enables: a stage takes a word when empty or draining
  assign rdy[3]   = !v_r[3] || dn_ready;
  assign rdy[2]   = !v_r[2] || rdy[3];
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign up_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
    end
  end

  // Stage 1: exposure products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_prod_nxt[i] = PROD_W'(up_pix[i]) * PROD_W'(gain);
    end
  end

  // Stage 2: saturate to Q8.16, weight for luminance
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_pix_nxt[i] = (|s1_prod_r[i][PROD_W-1:CH_W+16]) ? CH_MAX
                                                       : s1_prod_r[i][CH_W+15:16];
      s2_wp_nxt[i]  = WPROD_W'(s2_pix_nxt[i]) * WPROD_W'(LUM_WT[i]);
    end
  end

  // Stage 3: luminance sum; weights total 1.0 so it stays within Q8.16
  assign s3_sum     = (WPROD_W+2)'(s2_wp_r[0]) + (WPROD_W+2)'(s2_wp_r[1])
                    + (WPROD_W+2)'(s2_wp_r[2]);
  assign s3_lum_nxt = s3_sum[LUM_W+15:16];

  // Stage 4: scale operands and the dark pixel test
  assign s4_num_nxt    = ONE_Q32 + NUM_W'(NUM_W'(s3_lum_r) * NUM_W'(wsq));
  assign s4_den_nxt    = ONE_Q16 + DEN_W'(s3_lum_r);
  assign s4_bright_nxt = s3_lum_r > LUM_THRESH;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_prod_r <= s1_prod_nxt;
    end
    if (rdy[1]) begin
      s2_pix_r <= s2_pix_nxt;
      s2_wp_r  <= s2_wp_nxt;
    end
    if (rdy[2]) begin
      s3_pix_r <= s2_pix_r;
      s3_lum_r <= s3_lum_nxt;
    end
    if (rdy[3]) begin
      s4_pix_r    <= s3_pix_r;
      s4_bright_r <= s4_bright_nxt;
      s4_num_r    <= s4_num_nxt;
      s4_den_r    <= s4_den_nxt;
    end
  end

  assign dn_valid       = v_r[3];
  assign dn_data.pix    = s4_pix_r;
  assign dn_data.bright = s4_bright_r;
  assign dn_data.num    = s4_num_r;
  assign dn_data.den    = s4_den_r;

endmodule

// ===== rtl/rltm_div.sv =====
// Pipelined restoring divider: scale = (num << 8) / den, one quotient
// bit per stage, pixel carried alongside. Uses rltm_pkg.
`timescale 1ns / 1ps

module rltm_div import rltm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  div_in_t  up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output div_out_t dn_data
);

  localparam int LAST = DIV_STEPS - 1;

  logic [DIV_STEPS-1:0] v_r;
  logic [DIV_STEPS-1:0] rdy;
  logic [DIV_STEPS-1:0] bright_r;
  logic [DEN_W-1:0]     rem_r [DIV_STEPS];
  logic [SCL_W-1:0]     lq_r  [DIV_STEPS];
  logic [DEN_W-1:0]     den_r [DIV_STEPS];
  pix_t                 pix_r [DIV_STEPS];

  // Source of each stage: the input word or the stage before
  logic [DIV_STEPS-1:0] src_v;
  logic [DIV_STEPS-1:0] src_bright;
  logic [DEN_W-1:0]     src_rem [DIV_STEPS];
  logic [SCL_W-1:0]     src_lq  [DIV_STEPS];
  logic [DEN_W-1:0]     src_den [DIV_STEPS];
  pix_t                 src_pix [DIV_STEPS];

  // Dividend is num << 8; its top bits start as the partial remainder,
  // which is already below den since the quotient fits SCL_W bits
  assign src_v[0]      = up_valid;
  assign src_bright[0] = up_data.bright;
  assign src_rem[0]    = up_data.num[NUM_W-1:NUM_W-DEN_W];
  assign src_lq[0]     = {up_data.num[NUM_W-DEN_W-1:0], 8'd0};
  assign src_den[0]    = up_data.den;
  assign src_pix[0]    = up_data.pix;

  genvar k;
  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_nxt;
      logic [SCL_W-1:0] lq_nxt;

      if (k > 0) begin : g_link
        assign src_v[k]      = v_r[k-1];
        assign src_bright[k] = bright_r[k-1];
        assign src_rem[k]    = rem_r[k-1];
        assign src_lq[k]     = lq_r[k-1];
        assign src_den[k]    = den_r[k-1];
        assign src_pix[k]    = pix_r[k-1];
      end

      if (k == LAST) begin : g_tail
        assign rdy[k] = !v_r[k] || dn_ready;
      end else begin : g_body
        assign rdy[k] = !v_r[k] || rdy[k+1];
      end

      // Shift in the next dividend bit, subtract when it fits
      assign trial   = {src_rem[k], src_lq[k][SCL_W-1]};
      assign diff    = trial - {1'b0, src_den[k]};
      assign ge      = trial >= {1'b0, src_den[k]};
      assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign lq_nxt  = {src_lq[k][SCL_W-2:0], ge};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_r[k] <= src_v[k];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          bright_r[k] <= src_bright[k];
          rem_r[k]    <= rem_nxt;
          lq_r[k]     <= lq_nxt;
          den_r[k]    <= src_den[k];
          pix_r[k]    <= src_pix[k];
        end
      end
    end
  endgenerate

  assign up_ready       = rdy[0];
  assign dn_valid       = v_r[LAST];
  assign dn_data.pix    = pix_r[LAST];
  assign dn_data.bright = bright_r[LAST];
  assign dn_data.scale  = lq_r[LAST];

  // Starting remainder must be below the divisor or the quotient overflows
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (up_valid && rdy[0]) |-> (up_data.num[NUM_W-1:NUM_W-DEN_W] < up_data.den))
    else $error("divider start remainder not below divisor");

  // Final remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] |-> (rem_r[LAST] < den_r[LAST]))
    else $error("divider remainder out of range");

endmodule

// ===== rtl/rltm_back.sv =====
// Back stages: multiply each channel by the scale, truncate, saturate
// and pick the exposed pixel for dark inputs. Uses rltm_pkg.
`timescale 1ns / 1ps

module rltm_back import rltm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  div_out_t up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output pix_t     dn_pix
);

  logic [1:0] v_r;
  logic [1:0] rdy;

  logic [2:0][MUL_W-1:0] m_r, m_nxt;
  pix_t                  pix_r;
  logic                  bright_r;
  pix_t                  out_r, out_nxt;

  assign rdy[1]   = !v_r[1] || dn_ready;
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign up_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
    end
  end

  // Stage 1: channel times scale (Q8.16 * Q.24)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_nxt[i] = MUL_W'(up_data.pix[i]) * MUL_W'(up_data.scale);
    end
  end

  // Stage 2: drop 24 fraction bits, saturate, bypass dark pixels
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!bright_r) begin
        out_nxt[i] = pix_r[i];
      end else if (m_r[i][MUL_W-1]) begin
        out_nxt[i] = CH_MAX;
      end else begin
        out_nxt[i] = m_r[i][MUL_W-2:SCL_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      m_r      <= m_nxt;
      pix_r    <= up_data.pix;
      bright_r <= up_data.bright;
    end
    if (rdy[1]) begin
      out_r <= out_nxt;
    end
  end

  assign dn_valid = v_r[1];
  assign dn_pix   = out_r;

endmodule

// ===== rtl/reinhard_luminance_tone_map_core.sv =====
// Top level of the Reinhard luminance tone map: configuration registers
// and the front, divider and back pipelines. Uses rltm_pkg and submodules.
//
//   Channel  Direction  Word                               Handshake
//   in_      slave      red, green, blue, Q8.16 each       in_tvalid / in_tready
//   out_     master     red, green, blue, Q8.16 each       out_tvalid / out_tready
//   cfg_     slave      register index, write data         cfg_valid / cfg_ready
//
// One pixel per clock sustained while out_tready stays high; 4 front stages,
// one divider stage per scale bit for 25, and 2 back stages.
// Reset clears all valid bits and loads gain 1.0 and white point 2.
// Each stage holds its word while the next one is full and stalled; empty
// stages still fill, so a held output never blocks input until all fill.
// Configuration writes are taken every cycle (cfg_ready is always high).
`timescale 1ns / 1ps

module reinhard_luminance_tone_map_core import rltm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input pixel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,    // red_in, green_in, blue_in
  // Result pixel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,   // red_out, green_out, blue_out
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [GAIN_W-1:0] gain_r;
  logic [WSQ_W-1:0]  wsq_r;

  logic     fd_valid, fd_ready;
  div_in_t  fd_data;
  logic     db_valid, db_ready;
  div_out_t db_data;
  pix_t     out_pix;

  // Configuration registers; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      wsq_r  <= WSQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EXPOSURE_GAIN: gain_r <= cfg_data[GAIN_W-1:0];
        CFG_INV_WHITE_SQ:  wsq_r  <= cfg_data[WSQ_W-1:0];
        default: ;
      endcase
    end
  end

  rltm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .gain     (gain_r),
    .wsq      (wsq_r),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_pix   (pix_t'(in_tdata)),
    .dn_valid (fd_valid),
    .dn_ready (fd_ready),
    .dn_data  (fd_data)
  );

  rltm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fd_valid),
    .up_ready (fd_ready),
    .up_data  (fd_data),
    .dn_valid (db_valid),
    .dn_ready (db_ready),
    .dn_data  (db_data)
  );

  rltm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (db_valid),
    .up_ready (db_ready),
    .up_data  (db_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_pix   (out_pix)
  );

  assign out_tdata = DATA_W'(out_pix);

  // Registers come out of reset at their defaults
  a_cfg_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> (gain_r == GAIN_RESET && wsq_r == WSQ_RESET))
    else $error("configuration registers not at reset values");

  // Input only stalls when the output is held
  a_no_free_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

endmodule

// ===== test/tone_map_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Reinhard luminance tone map core: watches the pixel, result
// and register channels, predicts every result word and compares it.
// Depends on rltm_pkg for widths, the pixel type and register indexes.

module tone_map_checker import rltm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,    // red_in, green_in, blue_in
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [DATA_W-1:0]     out_tdata,   // red_out, green_out, blue_out
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  // BT.709 weights in Q0.16 and the dark limit in raw Q8.16 units
  localparam logic [63:0] W_RED        = 64'd13933;
  localparam logic [63:0] W_GREEN      = 64'd46871;
  localparam logic [63:0] W_BLUE       = 64'd4732;
  localparam logic [63:0] LUM_DARK_MAX = 64'd65;
  localparam logic [63:0] CH_LIMIT     = 64'hFF_FFFF;

  // Register copies: gain 1.0, white point 2 after reset
  localparam logic [GAIN_W-1:0] GAIN_INIT = 24'h01_0000;
  localparam logic [WSQ_W-1:0]  WSQ_INIT  = 17'h0_4000;

  logic [GAIN_W-1:0] gain_r;
  logic [WSQ_W-1:0]  wsq_r;
  pix_t              tone_q[$];
  pix_t              want;
  pix_t              got;
  int                fails;

  function automatic logic [63:0] clamp24(input logic [63:0] v);
    return (v > CH_LIMIT) ? CH_LIMIT : v;
  endfunction

  function automatic string field_name(input int idx);
    case (idx)
      0:       return "red_out";
      1:       return "green_out";
      default: return "blue_out";
    endcase
  endfunction

  // Expose, form luminance, then apply the extended Reinhard scale
  function automatic pix_t tone_map(input pix_t px, input logic [GAIN_W-1:0] gain,
                                    input logic [WSQ_W-1:0] wsq);
    logic [63:0] ch [3];
    logic [63:0] lum;
    logic [63:0] num;
    logic [63:0] scale;
    pix_t        res;
    for (int i = 0; i < 3; i++) ch[i] = clamp24((64'(px[i]) * 64'(gain)) >> 16);
    lum = (W_RED * ch[0] + W_GREEN * ch[1] + W_BLUE * ch[2]) >> 16;
    // dark pixels pass through as exposed
    if (lum > LUM_DARK_MAX) begin
      num   = (64'd1 << 32) + lum * 64'(wsq);
      scale = (num << 8) / (64'd65536 + lum);
      for (int i = 0; i < 3; i++) ch[i] = clamp24((ch[i] * scale) >> 24);
    end
    for (int i = 0; i < 3; i++) res[i] = ch[i][CH_W-1:0];
    return res;
  endfunction

  // Track registers, queue predictions, compare result words
  always @(posedge clk) begin
    if (!rst_n) begin
      gain_r = GAIN_INIT;
      wsq_r  = WSQ_INIT;
      tone_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EXPOSURE_GAIN: gain_r = cfg_data[GAIN_W-1:0];
          CFG_INV_WHITE_SQ:  wsq_r  = cfg_data[WSQ_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) tone_q.push_back(tone_map(pix_t'(in_tdata), gain_r, wsq_r));
      if (out_tvalid && out_tready) begin
        got = pix_t'(out_tdata);
        if (tone_q.size() == 0) begin
          $error("out_tdata: no word expected, got %h", out_tdata);
          fails++;
        end else begin
          want = tone_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (got[i] !== want[i]) begin
              $error("%s: expected %h, got %h", field_name(i), want[i], got[i]);
              fails++;
            end
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= tone_q.size();
  end

endmodule

// ===== test/tb_reinhard_luminance_tone_map_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the Reinhard luminance tone map core: clock, reset,
// pixel and register stimulus, result back-pressure and the verdict.
// Depends on rltm_pkg, the core and tone_map_checker.

module tb_reinhard_luminance_tone_map_core;
  import rltm_pkg::*;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 11;
  localparam int PIPE_LATENCY     = 31;
  localparam int HOLD_CYCLES      = 200;
  localparam int RUN_LIMIT_CYCLES = 200000;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST  = '1;
  localparam logic [CH_W-1:0]      CH_ONE        = 24'h01_0000;

  typedef enum logic [1:0] {RDY_RANDOM, RDY_ALWAYS, RDY_HOLD} ready_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [DATA_W-1:0]     out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  ready_mode_t           rdy_mode;

  reinhard_luminance_tone_map_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tone_map_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic pix_t make_pix(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                    input logic [CH_W-1:0] b);
    return {b, g, r};
  endfunction

  // Mix of extremes, near-dark, around 1.0 and full-range values
  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CH_MAX;
      2:       return CH_W'($urandom_range(0, 127));
      3:       return CH_W'($urandom_range(24'h00_4000, 24'h04_0000));
      default: return CH_W'($urandom());
    endcase
  endfunction

  // Gray pixels near the dark limit show up now and then
  function automatic pix_t rand_pixel();
    logic [CH_W-1:0] v;
    v = CH_W'($urandom_range(40, 100));
    if ($urandom_range(0, 7) == 0) return make_pix(v, v, v);
    return make_pix(rand_channel(), rand_channel(), rand_channel());
  endfunction

  // Offer one pixel word and hold it until taken
  task automatic send_pixel(input pix_t px);
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random(input int count, input bit gaps);
    for (int k = 0; k < count; k++) begin
      send_pixel(rand_pixel());
      if (gaps && $urandom_range(0, 3) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  endtask

  // Stop offering, wait for every result, then let the pipe settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] gain,
                            input logic [CFG_DATA_W-1:0] wsq);
    wait_idle();
    write_reg(CFG_EXPOSURE_GAIN, gain);
    write_reg(CFG_INV_WHITE_SQ, wsq);
    cfg_valid <= 1'b0;
  endtask

  // Result side back-pressure: random bursts, one long hold-off on request
  initial begin : result_ready
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rdy_mode == RDY_HOLD && !held) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (rdy_mode == RDY_RANDOM && $urandom_range(0, 3) == 0) begin
        held = 1'b0;
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        if (rdy_mode != RDY_HOLD) held = 1'b0;
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Pixel and register stimulus
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] gain_w;
    logic [CFG_DATA_W-1:0] wsq_w;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rdy_mode  <= RDY_RANDOM;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: extremes, dark limit, single channels, bit patterns
    send_pixel(make_pix('0, '0, '0));
    send_pixel(make_pix(CH_MAX, CH_MAX, CH_MAX));
    send_pixel(make_pix(24'd65, 24'd65, 24'd65));
    send_pixel(make_pix(24'd66, 24'd66, 24'd66));
    send_pixel(make_pix(CH_MAX, '0, '0));
    send_pixel(make_pix('0, CH_MAX, '0));
    send_pixel(make_pix('0, '0, CH_MAX));
    send_pixel(make_pix(24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA));
    send_pixel(make_pix(24'h55_5555, 24'hAA_AAAA, 24'h55_5555));
    send_pixel(make_pix(CH_ONE, CH_ONE, CH_ONE));

    // Writes to unused indexes must leave both registers alone
    wait_idle();
    write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom()));
    write_reg(CFG_IDX_W'($urandom_range(3, 254)), CFG_DATA_W'($urandom()));
    write_reg(CFG_IDX_LAST, '1);
    cfg_valid <= 1'b0;
    send_pixel(make_pix(CH_ONE, CH_ONE, CH_ONE));
    send_random(120, 1'b1);

    // Largest gain, white point at infinity: exposure saturates
    set_config('1, '0);
    send_pixel(make_pix(24'd1, 24'd1, 24'd1));
    send_pixel(make_pix(CH_ONE, 24'h01_0001, CH_MAX));
    send_pixel(make_pix(CH_MAX, CH_MAX, CH_MAX));
    send_random(60, 1'b1);

    // Zero gain: everything dark
    set_config('0, CFG_DATA_W'(65536));
    send_random(30, 1'b1);

    // White register past 1.0 with junk in the high bits: scale above one
    set_config(CFG_DATA_W'(24'h02_0000), '1);
    send_pixel(make_pix(CH_MAX, CH_MAX, CH_MAX));
    send_pixel(make_pix(24'h80_0000, 24'h80_0000, 24'h80_0000));
    send_random(80, 1'b1);
    wait_idle();
    send_random(30, 1'b1);

    // Random settings; the middle one runs with a long result hold-off
    for (int p = 0; p < 3; p++) begin
      case ($urandom_range(0, 2))
        0:       gain_w = CFG_DATA_W'(1) << $urandom_range(0, CFG_DATA_W - 1);
        1:       gain_w = CFG_DATA_W'($urandom_range(0, 24'h03_FFFF));
        default: gain_w = CFG_DATA_W'($urandom());
      endcase
      wsq_w = CFG_DATA_W'($urandom());
      if ($urandom_range(0, 1) == 1) wsq_w[WSQ_W-1:0] = WSQ_W'($urandom_range(0, 65536));
      set_config(gain_w, wsq_w);
      if (p == 1) begin
        rdy_mode <= RDY_HOLD;
        send_random(100, 1'b0);
        rdy_mode <= RDY_RANDOM;
      end
      send_random(50, 1'b1);
    end

    // Closing stretch at full rate on both sides
    set_config(CFG_DATA_W'($urandom_range(24'h00_8000, 24'h04_0000)),
               CFG_DATA_W'($urandom_range(0, 65536)));
    rdy_mode <= RDY_ALWAYS;
    send_random(80, 1'b0);
    wait_idle();

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #(RUN_LIMIT_CYCLES * 2 * CLK_HALF);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
